### hdl/deq_pkg.sv
// Shared constants, types and ring arithmetic for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH  = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_LIST
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } req_t;

  // (pos + off) mod DEPTH, with pos and off both below DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, pos} + {1'b0, off};
    if (sum >= (AW + 1)'(DEPTH)) begin
      sum = sum - (AW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] pos);
    logic [AW-1:0] res;
    if (pos == '0) begin
      res = AW'(DEPTH - 1);
    end else begin
      res = pos - AW'(1);
    end
    return res;
  endfunction

endpackage

### hdl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/deq_front.sv
// Request intake: decodes commands, drops unused codes, buffers requests.
`timescale 1ns / 1ps

module deq_front import deq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_value,
  output logic        busy,
  output req_t        head,
  output logic        head_valid,
  input  logic        head_pop
);

  req_t             q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             legal;
  logic             push;
  op_t              op;

  always_comb begin
    legal = 1'b1;
    op    = OP_LIST;
    unique case (in_command)
      CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  op = OP_PUSH_BACK;
      CMD_POP_FRONT:  op = OP_POP_FRONT;
      CMD_POP_BACK:   op = OP_POP_BACK;
      CMD_LIST:       op = OP_LIST;
      default:        legal = 1'b0;
    endcase
  end

  assign busy       = (cnt_r == (QAW + 1)'(QDEPTH));
  assign push       = start && !busy && legal;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QAW'(wr_ptr_r + QAW'(1)) : wr_ptr_r;
    rd_ptr_nxt = head_pop ? QAW'(rd_ptr_r + QAW'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW + 1)'(push) - (QAW + 1)'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op, value: in_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/deq_back.sv
// Executor: applies requests to the ring in RAM and drives the result port.
`timescale 1ns / 1ps

module deq_back import deq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  req_t          head,
  input  logic          head_valid,
  output logic          head_pop,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [31:0]   ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [31:0]   ram_rdata,
  output logic          out_strobe,
  output logic [1:0]    out_status,
  output logic [31:0]   out_data,
  output logic          out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          strobe_r, strobe_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   data_r, data_nxt;
  logic          last_r, last_nxt;
  logic          is_full;
  logic          is_empty;
  logic [AW-1:0] back_pos;
  logic [AW-1:0] idx_next;

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign back_pos = ring_add(front_r, AW'(count_r - CW'(1)));
  assign idx_next = idx_r + AW'(1);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    data_nxt   = '0;
    last_nxt   = 1'b1;
    head_pop   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = front_r;
    ram_wdata  = head.value;
    ram_re     = 1'b0;
    ram_raddr  = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          unique case (head.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              strobe_nxt = 1'b1;
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                if (head.op == OP_PUSH_FRONT) begin
                  front_nxt = ring_dec(front_r);
                  ram_waddr = ring_dec(front_r);
                end else begin
                  ram_waddr = ring_add(front_r, AW'(count_r));
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP;
                if (head.op == OP_POP_FRONT) begin
                  ram_raddr = front_r;
                  // front stays put when the last entry leaves
                  if (count_r != CW'(1)) begin
                    front_nxt = ring_add(front_r, AW'(1));
                  end
                end else begin
                  ram_raddr = back_pos;
                end
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_r;
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        strobe_nxt = 1'b1;
        data_nxt   = ram_rdata;
        state_nxt  = S_IDLE;
      end
      S_LIST: begin
        // ram_rdata holds entry idx_r; fetch the next one behind it
        strobe_nxt = 1'b1;
        data_nxt   = ram_rdata;
        last_nxt   = (idx_r == AW'(count_r - CW'(1)));
        if (last_nxt) begin
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ring_add(front_r, idx_next);
          idx_nxt   = idx_next;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      front_r  <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
    end
    status_r <= status_nxt;
    data_r   <= data_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_last   = last_r;

endmodule

### hdl/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit values.
//
// Requests: start with in_command / in_value is taken when busy is low.
// Commands push at the front or back, pop from the front or back, or list
// the contents front to back. Unused command codes are taken and dropped.
// Results: out_status, out_data and out_last are valid for the single cycle
// in which out_strobe is high; the receiver cannot stall them.
// Every request with a used command code ends with a result that has
// out_last set; a dropped request gives no result.
// A two-entry request queue sits between the intake and the executor.
// Pops and listings go through the registered RAM read, and a listing gives one
// result per cycle; the executor takes no new request while a pop or listing
// is in progress. busy rises only when the request queue is full.
// Reset (rst_n low, synchronous) empties the deque and the request queue;
// RAM contents are left as they are and never read before written.
`timescale 1ns / 1ps

module double_ended_queue import deq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last
);

  req_t          head;
  logic          head_valid;
  logic          head_pop;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  deq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .in_value   (in_value),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  deq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  deq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_strobe (out_strobe),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

endmodule

### hdl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module deq_checker import deq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [31:0] out_data,
  input logic        out_last
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("result or busy right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_OK || out_status == ST_EMPTY ||
                    out_status == ST_FULL))
    else $error("undefined status code");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ST_OK |-> out_last && out_data == '0)
    else $error("error result not final or carries data");

  a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_status == ST_OK)
    else $error("listing burst broken");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_status (out_status),
  .out_data   (out_data),
  .out_last   (out_last)
);

### dv/double_ended_queue_test.sv
// Self-checking testbench for the double-ended queue: random and directed requests.
`timescale 1ns / 1ps

module double_ended_queue_test;
  import deq_pkg::*;

  // first of the command codes that the block takes and drops
  localparam logic [2:0] CMD_FIRST_UNUSED = CMD_LIST + 3'd1;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
  localparam int IDLE_PCT   = 28;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic        last;
  } outcome_t;

  class deque_scoreboard;
    logic [31:0] ring [DEPTH];
    int head;
    int fill;
    outcome_t pending[$];
    int errors;
    int requests;
    int results;
    int rejects;
    int empties;
    int listings;

    function void add_outcome(logic [1:0] st, logic [31:0] d, logic l);
      pending.push_back('{status: st, data: d, last: l});
    endfunction

    function void note_request(logic [2:0] cmd, logic [31:0] val);
      logic [31:0] got;
      requests++;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            rejects++;
            add_outcome(ST_FULL, '0, 1'b1);
          end else begin
            if (cmd == CMD_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              ring[head] = val;
            end else begin
              ring[(head + fill) % DEPTH] = val;
            end
            fill++;
            add_outcome(ST_OK, '0, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (fill == 0) begin
            empties++;
            add_outcome(ST_EMPTY, '0, 1'b1);
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              got = ring[head];
              // head stays put when the last entry leaves
              if (fill > 1) head = (head + 1) % DEPTH;
            end else begin
              got = ring[(head + fill - 1) % DEPTH];
            end
            fill--;
            add_outcome(ST_OK, got, 1'b1);
          end
        end
        CMD_LIST: begin
          if (fill == 0) begin
            empties++;
            add_outcome(ST_EMPTY, '0, 1'b1);
          end else begin
            listings++;
            for (int i = 0; i < fill; i++)
              add_outcome(ST_OK, ring[(head + i) % DEPTH], i == fill - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] d, logic l);
      outcome_t exp;
      results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status=%0d data=%h last=%b",
                 $time, st, d, l);
        return;
      end
      exp = pending.pop_front();
      if (st !== exp.status || d !== exp.data || l !== exp.last) begin
        errors++;
        $display("%0t: mismatch expected status=%0d data=%h last=%b,",
                 $time, exp.status, exp.data, exp.last);
        $display("%0t:          got status=%0d data=%h last=%b", $time, st, d, l);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_command = CMD_PUSH_FRONT;
  logic signed [31:0] in_value = '0;
  logic               out_strobe;
  logic [1:0]         out_status;
  logic signed [31:0] out_data;
  logic               out_last;

  deque_scoreboard sb = new();

  double_ended_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      sb.check_result(out_status, out_data, out_last);
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'hffff_ffff;
        default: v = 32'h0000_0000;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // holds start high until the request is taken
  task automatic send_request(logic [2:0] cmd, logic [31:0] val, bit may_idle);
    if (may_idle) begin
      // each cycle idles with IDLE_PCT percent odds
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        in_command <= 3'($urandom);
        in_value <= $urandom;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_command <= cmd;
    in_value <= val;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, val);
  endtask

  // push_pct / list_pct / junk_pct shape the mix; the rest are pops
  task automatic run_mix(int n, int push_pct, int list_pct, int junk_pct, bit may_idle);
    int r;
    int done;
    logic [2:0] cmd;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < junk_pct) begin
        cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      end else if (r < junk_pct + list_pct) begin
        cmd = CMD_LIST;
        done++;
      end else if (r < junk_pct + list_pct + push_pct) begin
        cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        done++;
      end else begin
        cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        done++;
      end
      send_request(cmd, pick_value(), may_idle);
    end
  endtask

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extremes, both ends, drops
    send_request(CMD_POP_FRONT, 32'h1234_5678, 1'b1);
    send_request(CMD_POP_BACK, 32'h0, 1'b1);
    send_request(CMD_LIST, 32'hffff_ffff, 1'b1);
    send_request(CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1);
    send_request(CMD_PUSH_BACK, 32'h8000_0000, 1'b1);
    send_request(CMD_PUSH_FRONT, 32'hffff_ffff, 1'b1);
    send_request(CMD_PUSH_BACK, 32'h0000_0000, 1'b1);
    send_request(CMD_LIST, 32'h0, 1'b1);
    send_request(CMD_POP_FRONT, 32'h0, 1'b1);
    send_request(CMD_POP_BACK, 32'h0, 1'b1);
    send_request(CMD_LIST, 32'h0, 1'b1);
    send_request(CMD_POP_FRONT, 32'h0, 1'b1);
    send_request(CMD_POP_BACK, 32'h0, 1'b1);
    send_request(CMD_POP_BACK, 32'h0, 1'b1);
    for (logic [3:0] c = 4'(CMD_FIRST_UNUSED); c <= 4'(CMD_LAST_UNUSED); c++)
      send_request(c[2:0], 32'h5555_aaaa, 1'b1);
    send_request(CMD_PUSH_BACK, 32'haaaa_aaaa, 1'b1);
    send_request(CMD_PUSH_FRONT, 32'h5555_5555, 1'b1);
    send_request(CMD_LIST, 32'h0, 1'b1);
    send_request(CMD_POP_FRONT, 32'h0, 1'b1);
    send_request(CMD_POP_FRONT, 32'h0, 1'b1);

    // fill past full back to back, list it all, then drain past empty
    run_mix(36, 100, 0, 0, 1'b0);
    send_request(CMD_LIST, pick_value(), 1'b0);
    run_mix(36, 0, 5, 3, 1'b1);
    run_mix(52, 55, 8, 4, 1'b1);

    // drop start in the cycle of the last accept so nothing is taken twice
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("%0d requests, %0d results checked", sb.requests, sb.results);
    $display("%0d full rejects, %0d empty answers, %0d non-empty listings",
             sb.rejects, sb.empties, sb.listings);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
